@@ hw/rtl/e2g_pkg.sv @@
`default_nettype none
package e2g_pkg;

    localparam int ANGLE_BITS    = 32;
    localparam int CORDIC_STAGES = 32;
    localparam int ANG_W         = ANGLE_BITS + 2;
    localparam int FRAC          = 60;
    localparam int POSF          = 20;

    localparam logic signed [63:0] ONE       = 64'sh1000_0000_0000_0000;
    localparam logic signed [63:0] A_Q       = 64'sd6378137000 <<< POSF;
    localparam logic signed [63:0] B_Q       = (64'sd6356752314 <<< POSF) + 64'sd257089;
    localparam logic signed [63:0] INV_PI    = 64'sh517C_C1B7_2722_0A95;
    localparam logic signed [63:0] INV_SQRT2 = 64'sh0B50_4F33_3F9D_E648;
    localparam logic signed [63:0] POLE_GATE = 64'sd1000 <<< POSF;
    localparam logic signed [63:0] D_Q       = A_Q - B_Q;

    typedef logic [CORDIC_STAGES-1:0][63:0] t_tab;

    // Data riding along with each beat through the pipeline.
    typedef struct packed {
        logic                    vld;
        logic                    pole;
        logic signed [ANG_W-1:0] alon;
        logic signed [31:0]      lat;
        logic signed [63:0]      zs;
        logic signed [63:0]      ps;
        logic signed [63:0]      ct;
        logic signed [63:0]      st;
        logic signed [63:0]      sp;
        logic signed [63:0]      cp;
        logic signed [63:0]      hp;
        logic signed [63:0]      hz;
        logic signed [63:0]      w;
        logic signed [63:0]      r;
    } t_side;

    // round(a*b / 2^s), ties away from zero on the magnitude
    function automatic logic signed [63:0] f_mulr(input logic signed [63:0] a,
                                                  input logic signed [63:0] b,
                                                  input int s);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] p;
        logic [63:0]  r;
        ua = a[63] ? 64'(-a) : 64'(a);
        ub = b[63] ? 64'(-b) : 64'(b);
        p  = 128'(ua) * 128'(ub);
        p  = p + (128'd1 << (s - 1));
        r  = 64'(p >> s);
        return (a[63] ^ b[63]) ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [63:0] f_rshr(input logic signed [63:0] v, input int s);
        if (s == 0) begin
            return v;
        end
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [63:0] f_udiv(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic signed [63:0] f_frac_div(input logic [63:0] n,
                                                      input logic [63:0] d);
        logic [63:0] nn;
        logic [63:0] q;
        nn = n;
        q  = '0;
        for (int k = 0; k < FRAC; k++) begin
            nn = nn << 1;
            q  = q << 1;
            if (nn >= d) begin
                nn   = nn - d;
                q[0] = 1'b1;
            end
        end
        return $signed(q);
    endfunction

    function automatic t_tab f_atab();
        t_tab              tab;
        logic signed [63:0] rad;
        logic signed [63:0] t;
        tab    = '0;
        tab[0] = f_rshr(ONE, 63 - ANGLE_BITS);
        for (int i = 1; i < CORDIC_STAGES; i++) begin
            rad = '0;
            for (int k = 0; k < 32; k++) begin
                if (i * (2 * k + 1) <= 62) begin
                    t   = $signed(f_udiv(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1)));
                    rad = (k % 2 == 1) ? rad - t : rad + t;
                end
            end
            tab[i] = f_rshr(f_mulr(rad, INV_PI, 64), 63 - ANGLE_BITS);
        end
        return tab;
    endfunction

    function automatic logic signed [63:0] f_inv_gain();
        logic signed [63:0] g;
        logic signed [63:0] f;
        logic [63:0]        t;
        logic               done;
        int                 sh;
        g = INV_SQRT2;
        for (int i = 1; i < CORDIC_STAGES; i++) begin
            sh = 2 * i;
            f  = ONE;
            if (sh <= FRAC) begin
                t    = 64'(ONE);
                done = 1'b0;
                for (int k = 1; k < 64; k++) begin
                    if (!done) begin
                        t = f_udiv((t >> sh) * 64'(2 * k - 1), 64'(2 * k));
                        if (t == 64'd0) begin
                            done = 1'b1;
                        end else begin
                            f = (k % 2 == 1) ? f - $signed(t) : f + $signed(t);
                        end
                    end
                end
            end
            g = f_mulr(g, f, FRAC);
        end
        return g;
    endfunction

    localparam t_tab               ATAB     = f_atab();
    localparam logic signed [63:0] INV_GAIN = f_inv_gain();
    localparam logic signed [63:0] RHO      = f_frac_div(64'(B_Q), 64'(A_Q));
    localparam logic signed [63:0] E2Q      = ONE - f_mulr(RHO, RHO, FRAC);
    localparam logic signed [63:0] C2Q      = f_mulr(D_Q, ONE + RHO, FRAC);
    localparam logic signed [63:0] C1Q      =
        (D_Q <<< 1) + f_mulr(D_Q, f_frac_div(64'(D_Q), 64'(B_Q)), FRAC);

    // accumulator angle to 2^-31 semicircle
    function automatic logic signed [63:0] f_out_ang(input logic signed [ANG_W-1:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        if (ANGLE_BITS < 32) begin
            return w <<< (32 - ANGLE_BITS);
        end
        return f_rshr(w, ANGLE_BITS - 32);
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/e2g_mul.sv @@
`default_nettype none
module e2g_mul
    import e2g_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic signed [63:0] i_a,
    input  wire logic signed [63:0] i_b,
    input  wire logic               i_half,
    input  wire t_side              i_side,
    output logic signed [63:0]      o_p,
    output t_side                   o_side
);

    logic [63:0]  r_ua, r_ub;
    logic         r_neg1, r_half1;
    logic [63:0]  r_p00, r_p01, r_p10, r_p11;
    logic         r_neg2, r_half2;
    logic [63:0]  r_q00, r_q11;
    logic [64:0]  r_mid;
    logic         r_neg3, r_half3;
    logic [127:0] r_prod;
    logic         r_neg4, r_half4;
    logic signed [63:0] r_p;
    t_side        r_sd [0:4];

    logic [127:0] n_prod;
    logic [63:0]  n_mag;

    always_comb begin
        n_prod = {r_q11, r_q00} + ({63'd0, r_mid} << 32)
               + (r_half3 ? (128'd1 << FRAC) : (128'd1 << (FRAC - 1)));
        n_mag  = r_half4 ? r_prod[FRAC+64:FRAC+1] : r_prod[FRAC+63:FRAC];
    end

    always_ff @(posedge i_clk) begin
        r_ua    <= i_a[63] ? 64'(-i_a) : 64'(i_a);
        r_ub    <= i_b[63] ? 64'(-i_b) : 64'(i_b);
        r_neg1  <= i_a[63] ^ i_b[63];
        r_half1 <= i_half;

        r_p00   <= 64'(r_ua[31:0])  * 64'(r_ub[31:0]);
        r_p01   <= 64'(r_ua[31:0])  * 64'(r_ub[63:32]);
        r_p10   <= 64'(r_ua[63:32]) * 64'(r_ub[31:0]);
        r_p11   <= 64'(r_ua[63:32]) * 64'(r_ub[63:32]);
        r_neg2  <= r_neg1;
        r_half2 <= r_half1;

        r_q00   <= r_p00;
        r_q11   <= r_p11;
        r_mid   <= {1'b0, r_p01} + {1'b0, r_p10};
        r_neg3  <= r_neg2;
        r_half3 <= r_half2;

        r_prod  <= n_prod;
        r_neg4  <= r_neg3;
        r_half4 <= r_half3;

        r_p     <= r_neg4 ? -$signed(n_mag) : $signed(n_mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) begin
                r_sd[i].vld <= 1'b0;
            end
        end else begin
            r_sd[0] <= i_side;
            for (int i = 0; i < 4; i++) begin
                r_sd[i+1] <= r_sd[i];
            end
        end
    end

    assign o_p    = r_p;
    assign o_side = r_sd[4];

endmodule
`default_nettype wire

@@ hw/rtl/e2g_vec.sv @@
`default_nettype none
module e2g_vec
    import e2g_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic signed [63:0] i_x,
    input  wire logic signed [63:0] i_y,
    input  wire t_side              i_side,
    output logic signed [63:0]      o_mag,
    output logic signed [ANG_W-1:0] o_ang,
    output t_side                   o_side
);

    localparam logic signed [ANG_W-1:0] HALF = ANG_W'(1) <<< (ANGLE_BITS - 1);

    logic signed [63:0]      r_ax, r_ay;
    t_side                   r_asd;
    logic signed [63:0]      r_x   [0:CORDIC_STAGES];
    logic signed [63:0]      r_y   [0:CORDIC_STAGES];
    logic signed [ANG_W-1:0] r_acc [0:CORDIC_STAGES];
    logic                    r_z   [0:CORDIC_STAGES];
    t_side                   r_sd  [0:CORDIC_STAGES];

    always_ff @(posedge i_clk) begin
        r_ax  <= i_x;
        r_ay  <= i_y;

        // left half plane folds over by a half turn
        r_z[0]  <= (r_ax == 64'sd0) && (r_ay == 64'sd0);
        r_x[0]  <= r_ax[63] ? -r_ax : r_ax;
        r_y[0]  <= r_ax[63] ? -r_ay : r_ay;
        r_acc[0] <= r_ax[63] ? (r_ay[63] ? -HALF : HALF) : '0;

        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (!r_y[i][63]) begin
                r_x[i+1]   <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1]   <= r_y[i] - (r_x[i] >>> i);
                r_acc[i+1] <= r_acc[i] + $signed(ATAB[i][ANG_W-1:0]);
            end else begin
                r_x[i+1]   <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1]   <= r_y[i] + (r_x[i] >>> i);
                r_acc[i+1] <= r_acc[i] - $signed(ATAB[i][ANG_W-1:0]);
            end
            r_z[i+1]  <= r_z[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asd.vld <= 1'b0;
            for (int i = 0; i <= CORDIC_STAGES; i++) begin
                r_sd[i].vld <= 1'b0;
            end
        end else begin
            r_asd   <= i_side;
            r_sd[0] <= r_asd;
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                r_sd[i+1] <= r_sd[i];
            end
        end
    end

    assign o_mag  = r_z[CORDIC_STAGES] ? 64'sd0 : r_x[CORDIC_STAGES];
    assign o_ang  = r_z[CORDIC_STAGES] ? '0 : r_acc[CORDIC_STAGES];
    assign o_side = r_sd[CORDIC_STAGES];

endmodule
`default_nettype wire

@@ hw/rtl/e2g_rot.sv @@
`default_nettype none
module e2g_rot
    import e2g_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic signed [ANG_W-1:0] i_ang,
    input  wire t_side              i_side,
    output logic signed [63:0]      o_cos,
    output logic signed [63:0]      o_sin,
    output t_side                   o_side
);

    logic signed [63:0]      r_x   [0:CORDIC_STAGES];
    logic signed [63:0]      r_y   [0:CORDIC_STAGES];
    logic signed [ANG_W-1:0] r_ang [0:CORDIC_STAGES];
    t_side                   r_sd  [0:CORDIC_STAGES];

    always_ff @(posedge i_clk) begin
        r_x[0]   <= INV_GAIN;
        r_y[0]   <= 64'sd0;
        r_ang[0] <= i_ang;

        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (!r_ang[i][ANG_W-1]) begin
                r_x[i+1]   <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1]   <= r_y[i] + (r_x[i] >>> i);
                r_ang[i+1] <= r_ang[i] - $signed(ATAB[i][ANG_W-1:0]);
            end else begin
                r_x[i+1]   <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1]   <= r_y[i] - (r_x[i] >>> i);
                r_ang[i+1] <= r_ang[i] + $signed(ATAB[i][ANG_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= CORDIC_STAGES; i++) begin
                r_sd[i].vld <= 1'b0;
            end
        end else begin
            r_sd[0] <= i_side;
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                r_sd[i+1] <= r_sd[i];
            end
        end
    end

    assign o_cos  = r_x[CORDIC_STAGES];
    assign o_sin  = r_y[CORDIC_STAGES];
    assign o_side = r_sd[CORDIC_STAGES];

endmodule
`default_nettype wire

@@ hw/rtl/ecef_to_geodetic_convert.sv @@
// Channel   Direction  Handshake            Payload
// command   in         start, busy          i_pos_x, i_pos_y, i_pos_z (35b signed mm)
// result    out        o_done (one cycle)   o_latitude, o_longitude, o_height, o_near_pole
//
// Fully pipelined: one beat per cycle, busy is always low.
// Pipeline depth is set by three vectoring and two rotation CORDICs (one
// stage per iteration) and a chain of 21 five-stage 64x64 multipliers, most
// of them in the reciprocal square root.
// Synchronous active-low reset clears the valid bits only.
// The result side cannot stall; each result shows for one cycle with o_done.
`default_nettype none
module ecef_to_geodetic_convert
    import e2g_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [34:0] i_pos_x,
    input  wire logic signed [34:0] i_pos_y,
    input  wire logic signed [34:0] i_pos_z,
    output logic                    o_done,
    output logic signed [31:0]      o_latitude,
    output logic signed [31:0]      o_longitude,
    output logic signed [34:0]      o_height,
    output logic                    o_near_pole
);

    logic signed [63:0] xs, ys, zs;
    t_side s0, s1, s1b, s2, s2b, s3, s4, s5, s5b, s6, s7, s8, s9, s9b, s10, s10b;
    t_side s11, s11b, s12, s12b, s13, s14;
    t_side sn [0:4];

    logic signed [ANG_W-1:0] alon_v, th, phi;
    logic signed [63:0] mp, ps_m, q, ct, st, s2q, c2q_v, s3q, c3q, t1, t2;
    logic signed [63:0] num, den, den_c, cp, sp, sp2, hp, hz, e2s, wr, an;
    logic signed [63:0] lat_w, hq, hr, zabs;

    logic               r_done, r_pole;
    logic signed [31:0] r_lat, r_lon;
    logic signed [34:0] r_h;

    assign busy = 1'b0;

    assign xs = {{9{i_pos_x[34]}}, i_pos_x, 20'd0};
    assign ys = {{9{i_pos_y[34]}}, i_pos_y, 20'd0};
    assign zs = {{9{i_pos_z[34]}}, i_pos_z, 20'd0};

    always_comb begin
        s0     = '0;
        s0.vld = start;
        s0.zs  = zs;
    end

    e2g_vec u_v_lon (.i_clk, .i_rst_n, .i_x(xs), .i_y(ys), .i_side(s0),
                     .o_mag(mp), .o_ang(alon_v), .o_side(s1));

    always_comb begin
        s1b      = s1;
        s1b.alon = alon_v;
    end

    e2g_mul u_m_p (.i_clk, .i_rst_n, .i_a(mp), .i_b(INV_GAIN), .i_half(1'b0),
                   .i_side(s1b), .o_p(ps_m), .o_side(s2));

    always_comb begin
        s2b      = s2;
        s2b.ps   = ps_m;
        s2b.pole = (ps_m <= POLE_GATE);
    end

    e2g_mul u_m_q (.i_clk, .i_rst_n, .i_a(ps_m), .i_b(RHO), .i_half(1'b0),
                   .i_side(s2b), .o_p(q), .o_side(s3));

    logic signed [63:0] mth;
    e2g_vec u_v_th (.i_clk, .i_rst_n, .i_x(q), .i_y(s3.zs), .i_side(s3),
                    .o_mag(mth), .o_ang(th), .o_side(s4));

    e2g_rot u_r_th (.i_clk, .i_rst_n, .i_ang(th), .i_side(s4),
                    .o_cos(ct), .o_sin(st), .o_side(s5));

    always_comb begin
        s5b    = s5;
        s5b.ct = ct;
        s5b.st = st;
    end

    e2g_mul u_m_s2 (.i_clk, .i_rst_n, .i_a(st), .i_b(st), .i_half(1'b0),
                    .i_side(s5b), .o_p(s2q), .o_side(s6));
    e2g_mul u_m_c2 (.i_clk, .i_rst_n, .i_a(ct), .i_b(ct), .i_half(1'b0),
                    .i_side(s5b), .o_p(c2q_v), .o_side());
    e2g_mul u_m_s3 (.i_clk, .i_rst_n, .i_a(s2q), .i_b(s6.st), .i_half(1'b0),
                    .i_side(s6), .o_p(s3q), .o_side(s7));
    e2g_mul u_m_c3 (.i_clk, .i_rst_n, .i_a(c2q_v), .i_b(s6.ct), .i_half(1'b0),
                    .i_side(s6), .o_p(c3q), .o_side());
    e2g_mul u_m_t1 (.i_clk, .i_rst_n, .i_a(s3q), .i_b(C1Q), .i_half(1'b0),
                    .i_side(s7), .o_p(t1), .o_side(s8));
    e2g_mul u_m_t2 (.i_clk, .i_rst_n, .i_a(c3q), .i_b(C2Q), .i_half(1'b0),
                    .i_side(s7), .o_p(t2), .o_side());

    // interior points can drive the denominator negative
    assign num   = s8.zs + t1;
    assign den   = s8.ps - t2;
    assign den_c = den[63] ? 64'sd0 : den;

    logic signed [63:0] mph;
    e2g_vec u_v_lat (.i_clk, .i_rst_n, .i_x(den_c), .i_y(num), .i_side(s8),
                     .o_mag(mph), .o_ang(phi), .o_side(s9));

    always_comb begin
        lat_w = f_out_ang(phi);
        if (lat_w > (64'sd1 <<< 30)) begin
            lat_w = 64'sd1 <<< 30;
        end
        if (lat_w < -(64'sd1 <<< 30)) begin
            lat_w = -(64'sd1 <<< 30);
        end
        s9b     = s9;
        s9b.lat = lat_w[31:0];
    end

    e2g_rot u_r_lat (.i_clk, .i_rst_n, .i_ang(phi), .i_side(s9b),
                     .o_cos(cp), .o_sin(sp), .o_side(s10));

    always_comb begin
        s10b    = s10;
        s10b.cp = cp;
        s10b.sp = sp;
    end

    e2g_mul u_m_sp2 (.i_clk, .i_rst_n, .i_a(sp), .i_b(sp), .i_half(1'b0),
                     .i_side(s10b), .o_p(sp2), .o_side(s11));
    e2g_mul u_m_hp (.i_clk, .i_rst_n, .i_a(s10b.ps), .i_b(cp), .i_half(1'b0),
                    .i_side(s10b), .o_p(hp), .o_side());
    e2g_mul u_m_hz (.i_clk, .i_rst_n, .i_a(s10b.zs), .i_b(sp), .i_half(1'b0),
                    .i_side(s10b), .o_p(hz), .o_side());

    always_comb begin
        s11b    = s11;
        s11b.hp = hp;
        s11b.hz = hz;
    end

    e2g_mul u_m_e2 (.i_clk, .i_rst_n, .i_a(E2Q), .i_b(sp2), .i_half(1'b0),
                    .i_side(s11b), .o_p(e2s), .o_side(s12));

    always_comb begin
        s12b   = s12;
        s12b.w = ONE - e2s;
        s12b.r = ONE;
        sn[0]  = s12b;
    end

    // four Newton steps toward 1/sqrt(w)
    for (genvar k = 0; k < 4; k++) begin : g_nr
        logic signed [63:0] rr, dw, dl;
        t_side sa, sb, sc;

        e2g_mul u_rr (.i_clk, .i_rst_n, .i_a(sn[k].r), .i_b(sn[k].r), .i_half(1'b0),
                      .i_side(sn[k]), .o_p(rr), .o_side(sa));
        e2g_mul u_dw (.i_clk, .i_rst_n, .i_a(sa.w), .i_b(rr), .i_half(1'b0),
                      .i_side(sa), .o_p(dw), .o_side(sb));
        e2g_mul u_dl (.i_clk, .i_rst_n, .i_a(ONE - dw), .i_b(sb.r), .i_half(1'b1),
                      .i_side(sb), .o_p(dl), .o_side(sc));

        always_comb begin
            sn[k+1]   = sc;
            sn[k+1].r = sc.r + dl;
        end
    end

    e2g_mul u_m_wr (.i_clk, .i_rst_n, .i_a(sn[4].w), .i_b(sn[4].r), .i_half(1'b0),
                    .i_side(sn[4]), .o_p(wr), .o_side(s13));
    e2g_mul u_m_an (.i_clk, .i_rst_n, .i_a(A_Q), .i_b(wr), .i_half(1'b0),
                    .i_side(s13), .o_p(an), .o_side(s14));

    always_comb begin
        zabs = s14.zs[63] ? -s14.zs : s14.zs;
        hq   = s14.pole ? (zabs - B_Q) : (s14.hp + s14.hz - an);
        hr   = f_rshr(hq, POSF);
        if (hr > ((64'sd1 <<< 34) - 64'sd1)) begin
            hr = (64'sd1 <<< 34) - 64'sd1;
        end
        if (hr < -(64'sd1 <<< 34)) begin
            hr = -(64'sd1 <<< 34);
        end
    end

    always_ff @(posedge i_clk) begin
        r_lat  <= s14.lat;
        r_lon  <= 32'(f_out_ang(s14.alon));
        r_h    <= hr[34:0];
        r_pole <= s14.pole;
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= s14.vld;
        end
    end

    assign o_done      = r_done;
    assign o_latitude  = r_lat;
    assign o_longitude = r_lon;
    assign o_height    = r_h;
    assign o_near_pole = r_pole;

endmodule
`default_nettype wire
